[src/prbc_pkg.sv]
// Shared types, codes, constants and arithmetic helpers for the rigid body classifier.
`timescale 1ns / 1ps

package prbc_pkg;

    // Table size and index widths.
    localparam int MAX_BODIES = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;

    // CORDIC setup: step count, start vector gain in Q2.30 and 2*pi in Q3.29.
    localparam int          CORDIC_STEPS = 28;
    localparam logic [59:0] CORDIC_GAIN  = 60'd652032874;
    localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;

    // Opcodes of an input item.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Body kinds.
    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;

    // Result outcomes.
    localparam logic [1:0] OUT_DEEP    = 2'd0;
    localparam logic [1:0] OUT_HIT     = 2'd1;
    localparam logic [1:0] OUT_OUTSIDE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DIMENSION    = 2'd0;
    localparam logic [1:0] CFG_BODY_COUNT   = 2'd1;
    localparam logic [1:0] CFG_BASE_SPACING = 2'd2;
    localparam logic [1:0] CFG_REFINE_LEVEL = 2'd3;

    // Dimension code that selects 3D rules.
    localparam logic [1:0] DIM_3D = 2'd3;

    // One table entry as stored in the body memory.
    typedef struct packed {
        logic [1:0]         kind;
        logic [30:0]        extent;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [15:0]        angle;
    } t_body;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // Applies a sign to an unsigned magnitude product.
    function automatic logic signed [65:0] sgn_prod(input logic [63:0] p, input logic neg);
        logic signed [65:0] v;
        v = $signed({2'b00, p});
        return neg ? -v : v;
    endfunction

endpackage

[src/prbc_ram.sv]
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module prbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, read every cycle into a registered output.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/point_in_rigid_body_classifier_core.sv]
// Top level of the point in rigid body classifier: body table, walk sequencer and datapath.
`timescale 1ns / 1ps

// A load item writes one body entry and gives no result. A query walks
// the entries 0 to body_count-1 (at most 16) one after another and stops at the first
// verdict. A circle is first decided by its distance; a 2D circle that is not decided
// that way may need the surface point test. That test uses the shared iterative units: a
// restoring divider that retires one quotient bit a cycle (64 bits for the surface point
// count, 32 bits for each surface angle) and one CORDIC stage that runs 28 steps per
// angle or sine and cosine. The body table is a 16 entry memory with registered read.
// The result waits in an output register, so a new item is taken while it is pending.
module point_in_rigid_body_classifier_core
    import prbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_in_opcode,
    input  logic [3:0]         i_in_body_index,
    input  logic [1:0]         i_in_body_kind,
    input  logic [30:0]        i_in_body_extent,
    input  logic signed [31:0] i_in_coord_x,
    input  logic signed [31:0] i_in_coord_y,
    input  logic signed [31:0] i_in_coord_z,
    input  logic [15:0]        i_in_body_angle,
    input  logic [30:0]        i_in_spacing_h,
    input  logic signed [4:0]  i_in_attached_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_out_outcome,
    output logic [3:0]         o_out_hit_index
);

    typedef enum logic [5:0] {
        S_IDLE, S_READ, S_FETCH, S_KIND,
        S_C_SQX, S_C_SQY, S_C_SQZ, S_C_RMH, S_C_R2, S_C_RPH, S_C_SURF,
        S_C_MNUM, S_C_MDIV, S_C_MWAIT, S_C_MSCALE, S_C_MCHK, S_C_AWAIT, S_C_AFIN,
        S_C_KMUL, S_C_KFIX, S_C_FSTART, S_C_FWAIT, S_C_SSTART, S_C_SWAIT, S_C_SFIN,
        S_C_EXM, S_C_EYM, S_C_EXSQ, S_C_EYSQ, S_C_HSQ, S_C_NEAR,
        S_Q_SWAIT, S_Q_SFIN, S_Q_P1, S_Q_P2, S_Q_P3, S_Q_P4, S_Q_RY, S_Q_TEST,
        S_NEXT, S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [1:0]       r_dim;
    logic [CNT_W-1:0] r_count;
    logic [30:0]      r_h0;
    logic [3:0]       r_refine;

    // Query, walk and result registers.
    logic signed [31:0] r_px, r_py, r_pz;
    logic [30:0]        r_h;
    logic signed [4:0]  r_att;
    logic [CNT_W-1:0]   r_idx;
    logic               r_pt;
    logic               r_out_valid;
    logic [1:0]         r_outcome;
    logic [IDX_W-1:0]   r_hit_index;

    // Current body.
    logic [1:0]         r_kind;
    logic [30:0]        r_r;
    logic [15:0]        r_ang;
    logic signed [32:0] r_dx, r_dy, r_dz;

    // Multiplier, accumulators and intermediate values.
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        r_prod;
    logic [65:0]        r_d2;
    logic [39:0]        r_m;
    logic [31:0]        r_t;
    logic [39:0]        r_k;
    logic signed [32:0] r_cs, r_sn;
    logic signed [35:0] r_ex, r_ey;
    logic [65:0]        r_s;
    logic signed [65:0] r_acc;
    logic signed [35:0] r_rx, r_ry;

    // CORDIC stage.
    logic signed [59:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic               r_crot;
    logic [4:0]         r_cstep;
    logic [1:0]         r_quad;

    // Divider.
    logic [59:0] r_drem, r_dden;
    logic [63:0] r_dnum, r_dquo;
    logic [6:0]  r_dcnt;

    t_body ram_wdata, ram_rdata;
    logic  ram_we;
    logic  in_xfer, three_d, other;
    logic [CNT_W-1:0] cnt_eff;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign three_d    = (r_dim == DIM_3D);
    assign other      = (r_att != $signed(r_idx));
    assign cnt_eff    = (r_count > CNT_W'(MAX_BODIES)) ? CNT_W'(MAX_BODIES) : r_count;

    // Body table.
    assign ram_we           = in_xfer && (i_in_opcode == OP_LOAD);
    assign ram_wdata.kind   = i_in_body_kind;
    assign ram_wdata.extent = i_in_body_extent;
    assign ram_wdata.cx     = i_in_coord_x;
    assign ram_wdata.cy     = i_in_coord_y;
    assign ram_wdata.cz     = i_in_coord_z;
    assign ram_wdata.angle  = i_in_body_angle;

    prbc_ram #(
        .WIDTH($bits(t_body)),
        .DEPTH(MAX_BODIES)
    ) u_body_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_body_index),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Magnitudes that feed the unsigned multiplier.
    logic [32:0] dx_mag, dy_mag, dz_mag, cs_mag, sn_mag;
    logic [35:0] ex_mag, ey_mag, rx_mag, ry_mag;

    always_comb begin
        dx_mag = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
        dy_mag = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
        dz_mag = r_dz[32] ? 33'(-r_dz) : 33'(r_dz);
        cs_mag = r_cs[32] ? 33'(-r_cs) : 33'(r_cs);
        sn_mag = r_sn[32] ? 33'(-r_sn) : 33'(r_sn);
        ex_mag = r_ex[35] ? 36'(-r_ex) : 36'(r_ex);
        ey_mag = r_ey[35] ? 36'(-r_ey) : 36'(r_ey);
        rx_mag = r_rx[35] ? 36'(-r_rx) : 36'(r_rx);
        ry_mag = r_ry[35] ? 36'(-r_ry) : 36'(r_ry);
    end

    logic [31:0] rmh, rph;
    assign rmh = {1'b0, r_r} - {1'b0, r_h};
    assign rph = {1'b0, r_r} + {1'b0, r_h};

    // Operand selection for the shared 32 by 32 multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_C_SQX:  begin mul_a = dx_mag[31:0]; mul_b = dx_mag[31:0]; end
            S_C_SQY:  begin mul_a = dy_mag[31:0]; mul_b = dy_mag[31:0]; end
            S_C_SQZ:  begin mul_a = dz_mag[31:0]; mul_b = dz_mag[31:0]; end
            S_C_RMH:  begin mul_a = rmh;          mul_b = rmh;          end
            S_C_R2:   begin mul_a = {1'b0, r_r};  mul_b = {1'b0, r_r};  end
            S_C_RPH:  begin mul_a = rph;          mul_b = rph;          end
            S_C_MNUM: begin mul_a = TWO_PI_Q29;   mul_b = {1'b0, r_r};  end
            S_C_KMUL: begin mul_a = r_t;          mul_b = r_m[31:0];    end
            S_C_EXM:  begin mul_a = {1'b0, r_r};  mul_b = cs_mag[31:0]; end
            S_C_EYM:  begin mul_a = {1'b0, r_r};  mul_b = sn_mag[31:0]; end
            S_C_EXSQ: begin mul_a = ex_mag[31:0]; mul_b = ex_mag[31:0]; end
            S_C_EYSQ: begin mul_a = ey_mag[31:0]; mul_b = ey_mag[31:0]; end
            S_C_HSQ:  begin mul_a = {1'b0, r_h};  mul_b = {1'b0, r_h};  end
            S_Q_P1:   begin mul_a = cs_mag[31:0]; mul_b = dx_mag[31:0]; end
            S_Q_P2:   begin mul_a = sn_mag[31:0]; mul_b = dy_mag[31:0]; end
            S_Q_P3:   begin mul_a = cs_mag[31:0]; mul_b = dy_mag[31:0]; end
            S_Q_P4:   begin mul_a = sn_mag[31:0]; mul_b = dx_mag[31:0]; end
            default:  begin mul_a = '0;           mul_b = '0;           end
        endcase
    end

    // CORDIC stage: one micro-rotation per cycle in rotation or vectoring mode.
    logic signed [59:0] cx_sh, cy_sh;
    logic signed [33:0] c_atan;
    logic               c_pos;
    logic [31:0]        rot_a, rot_ap, rot_d;
    logic [1:0]         rot_q;
    logic signed [59:0] vx0, vy0;

    always_comb begin
        cx_sh  = r_cx >>> r_cstep;
        cy_sh  = r_cy >>> r_cstep;
        c_atan = atan_turns(r_cstep);
        c_pos  = r_crot ? !r_cz[33] : r_cy[59];
        rot_a  = (r_state == S_KIND) ? {r_ang, 16'h0000} : r_dquo[31:0];
        rot_ap = rot_a + 32'h2000_0000;
        rot_q  = rot_ap[31:30];
        rot_d  = rot_a - {rot_q, 30'd0};
        vx0    = {{3{r_dx[32]}}, r_dx, 24'd0};
        vy0    = {{3{r_dy[32]}}, r_dy, 24'd0};
    end

    // Quadrant fix-up of the rotated vector.
    logic signed [32:0] q_cs, q_sn, cx33, cy33;

    always_comb begin
        cx33 = r_cx[32:0];
        cy33 = r_cy[32:0];
        case (r_quad)
            2'd0:    begin q_cs = cx33;  q_sn = cy33;  end
            2'd1:    begin q_cs = -cy33; q_sn = cx33;  end
            2'd2:    begin q_cs = -cx33; q_sn = -cy33; end
            default: begin q_cs = cy33;  q_sn = -cx33; end
        endcase
    end

    // Divider step: one restoring quotient bit per cycle.
    logic [60:0] d_rem2;
    logic        d_ge;
    assign d_rem2 = {r_drem, r_dnum[63]};
    assign d_ge   = d_rem2 >= {1'b0, r_dden};

    // Surface point helpers.
    logic [40:0] k_raw;
    logic [39:0] k_fix, j_next, j_sel;
    logic [39:0] m_scaled;
    logic signed [65:0] p_signed_cs, p_signed_sn, p_sh_cs, p_sh_sn;
    logic signed [35:0] dx36, dy36;

    always_comb begin
        k_raw       = 41'(r_t * r_m[39:32]) + {9'd0, r_prod[63:32]};
        k_fix       = (k_raw >= {1'b0, r_m}) ? (r_m - 40'd1) : k_raw[39:0];
        j_next      = ((r_k + 40'd1) == r_m) ? 40'd0 : (r_k + 40'd1);
        j_sel       = r_pt ? j_next : r_k;
        m_scaled    = r_dquo[34:0] * ({1'b0, r_refine} + 5'd1);
        p_signed_cs = sgn_prod(r_prod, r_cs[32]);
        p_signed_sn = sgn_prod(r_prod, r_sn[32]);
        p_sh_cs     = p_signed_cs >>> 30;
        p_sh_sn     = p_signed_sn >>> 30;
        dx36        = 36'(r_dx);
        dy36        = 36'(r_dy);
    end

    // Decisions taken by the sequencer.
    logic d2_lt, d2_le, circ_deep, circ_hit, surf_go, near_hit;
    logic signed [39:0] sq_deep_lim;
    logic [39:0]        sq_hit_lim;
    logic               sq_deep, sq_hit;

    always_comb begin
        d2_lt       = r_d2 < {2'b00, r_prod};
        d2_le       = r_d2 <= {2'b00, r_prod};
        circ_deep   = (r_r > r_h) && d2_lt;
        circ_hit    = d2_le && other;
        surf_go     = !three_d && d2_lt && other && (r_h0 != '0);
        near_hit    = (ex_mag < 36'h4000_0000) && (ey_mag < 36'h4000_0000)
                      && ({r_s[63:0], 2'b00} < {2'b00, r_prod});
        sq_deep_lim = $signed({8'd0, r_r, 1'b0}) - $signed({9'd0, r_h})
                      - $signed({8'd0, r_h, 1'b0});
        sq_hit_lim  = {7'd0, r_r, 2'b00} + {9'd0, r_h};
        sq_deep     = ($signed({3'd0, rx_mag, 1'b0}) < sq_deep_lim)
                      && ($signed({3'd0, ry_mag, 1'b0}) < sq_deep_lim);
        sq_hit      = ({2'd0, rx_mag, 2'b00} < sq_hit_lim)
                      && ({2'd0, ry_mag, 2'b00} < sq_hit_lim);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim    <= 2'd2;
            r_count  <= '0;
            r_h0     <= 31'd65536;
            r_refine <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIMENSION:    r_dim    <= i_cfg_data[1:0];
                CFG_BODY_COUNT:   r_count  <= i_cfg_data[CNT_W-1:0];
                CFG_BASE_SPACING: r_h0     <= i_cfg_data;
                CFG_REFINE_LEVEL: r_refine <= i_cfg_data[3:0];
                default:          r_dim    <= r_dim;
            endcase
        end
    end

    // Walk sequencer with the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_pt        <= 1'b0;
            r_outcome   <= OUT_OUTSIDE;
            r_hit_index <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_in_opcode == OP_QUERY)) begin
                        r_idx       <= '0;
                        r_outcome   <= OUT_OUTSIDE;
                        r_hit_index <= '0;
                        r_state     <= (cnt_eff == '0) ? S_OUT : S_READ;
                    end
                end
                S_READ:     r_state <= S_FETCH;
                S_FETCH:    r_state <= S_KIND;
                S_KIND: begin
                    if (r_kind == KIND_CIRCLE) begin
                        r_state <= S_C_SQX;
                    end else if (r_kind == KIND_SQUARE && !three_d) begin
                        r_state <= S_Q_SWAIT;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_C_SQX:    r_state <= S_C_SQY;
                S_C_SQY:    r_state <= S_C_SQZ;
                S_C_SQZ:    r_state <= S_C_RMH;
                S_C_RMH:    r_state <= S_C_R2;
                S_C_R2: begin
                    if (circ_deep) begin
                        r_outcome <= OUT_DEEP;
                        r_state   <= S_OUT;
                    end else begin
                        r_state <= S_C_RPH;
                    end
                end
                S_C_RPH: begin
                    if (circ_hit) begin
                        r_outcome   <= OUT_HIT;
                        r_hit_index <= r_idx[IDX_W-1:0];
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_C_SURF;
                    end
                end
                S_C_SURF:   r_state <= surf_go ? S_C_MNUM : S_NEXT;
                S_C_MNUM:   r_state <= S_C_MDIV;
                S_C_MDIV:   r_state <= S_C_MWAIT;
                S_C_MWAIT:  if (r_dcnt == 7'd1) r_state <= S_C_MSCALE;
                S_C_MSCALE: r_state <= S_C_MCHK;
                S_C_MCHK: begin
                    if (r_m == '0) begin
                        r_state <= S_NEXT;
                    end else if (r_dx == '0 && r_dy == '0) begin
                        r_state <= S_C_KMUL;
                    end else begin
                        r_state <= S_C_AWAIT;
                    end
                end
                S_C_AWAIT:  if (r_cstep == 5'(CORDIC_STEPS - 1)) r_state <= S_C_AFIN;
                S_C_AFIN:   r_state <= S_C_KMUL;
                S_C_KMUL:   r_state <= S_C_KFIX;
                S_C_KFIX: begin
                    r_pt    <= 1'b0;
                    r_state <= S_C_FSTART;
                end
                S_C_FSTART: r_state <= S_C_FWAIT;
                S_C_FWAIT:  if (r_dcnt == 7'd1) r_state <= S_C_SSTART;
                S_C_SSTART: r_state <= S_C_SWAIT;
                S_C_SWAIT:  if (r_cstep == 5'(CORDIC_STEPS - 1)) r_state <= S_C_SFIN;
                S_C_SFIN:   r_state <= S_C_EXM;
                S_C_EXM:    r_state <= S_C_EYM;
                S_C_EYM:    r_state <= S_C_EXSQ;
                S_C_EXSQ:   r_state <= S_C_EYSQ;
                S_C_EYSQ:   r_state <= S_C_HSQ;
                S_C_HSQ:    r_state <= S_C_NEAR;
                S_C_NEAR: begin
                    if (near_hit) begin
                        r_outcome   <= OUT_HIT;
                        r_hit_index <= r_idx[IDX_W-1:0];
                        r_state     <= S_OUT;
                    end else if (!r_pt) begin
                        r_pt    <= 1'b1;
                        r_state <= S_C_FSTART;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_Q_SWAIT:  if (r_cstep == 5'(CORDIC_STEPS - 1)) r_state <= S_Q_SFIN;
                S_Q_SFIN:   r_state <= S_Q_P1;
                S_Q_P1:     r_state <= S_Q_P2;
                S_Q_P2:     r_state <= S_Q_P3;
                S_Q_P3:     r_state <= S_Q_P4;
                S_Q_P4:     r_state <= S_Q_RY;
                S_Q_RY:     r_state <= S_Q_TEST;
                S_Q_TEST: begin
                    if (sq_deep) begin
                        r_outcome <= OUT_DEEP;
                        r_state   <= S_OUT;
                    end else if (sq_hit) begin
                        r_outcome   <= OUT_HIT;
                        r_hit_index <= r_idx[IDX_W-1:0];
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if ((r_idx + CNT_W'(1)) >= cnt_eff) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    // The result register takes the verdict once it is free.
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default:    r_state <= S_IDLE;
            endcase
        end
    end

    // Result fields follow the verdict into the output register.
    logic [1:0]       r_o_outcome;
    logic [IDX_W-1:0] r_o_hit;

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_o_outcome <= r_outcome;
            r_o_hit     <= r_hit_index;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_outcome   = r_o_outcome;
    assign o_out_hit_index = r_o_hit;

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);

        // Query capture.
        if (in_xfer) begin
            r_px  <= i_in_coord_x;
            r_py  <= i_in_coord_y;
            r_pz  <= i_in_coord_z;
            r_h   <= i_in_spacing_h;
            r_att <= i_in_attached_index;
        end

        case (r_state)
            S_FETCH: begin
                r_kind <= ram_rdata.kind;
                r_r    <= ram_rdata.extent;
                r_ang  <= ram_rdata.angle;
                r_dx   <= 33'(r_px) - 33'(ram_rdata.cx);
                r_dy   <= 33'(r_py) - 33'(ram_rdata.cy);
                r_dz   <= three_d ? (33'(r_pz) - 33'(ram_rdata.cz)) : 33'sd0;
            end
            S_KIND, S_C_SSTART: begin
                // Start a sine and cosine evaluation.
                r_crot  <= 1'b1;
                r_cstep <= '0;
                r_quad  <= rot_q;
                r_cx    <= CORDIC_GAIN;
                r_cy    <= '0;
                r_cz    <= 34'($signed(rot_d));
            end
            S_C_SQY:  r_d2 <= {2'b00, r_prod};
            S_C_SQZ:  r_d2 <= r_d2 + {2'b00, r_prod};
            S_C_RMH:  r_d2 <= r_d2 + {2'b00, r_prod};
            S_C_MDIV: begin
                // Surface point count: round(2*pi*r / h0).
                r_drem <= '0;
                r_dnum <= r_prod + {5'd0, r_h0, 28'd0};
                r_dden <= {r_h0, 29'd0};
                r_dquo <= '0;
                r_dcnt <= 7'd64;
            end
            S_C_MSCALE: r_m <= m_scaled;
            S_C_MCHK: begin
                // Start the point angle evaluation.
                r_t     <= '0;
                r_crot  <= 1'b0;
                r_cstep <= '0;
                r_cx    <= r_dx[32] ? -vx0 : vx0;
                r_cy    <= r_dx[32] ? -vy0 : vy0;
                r_cz    <= r_dx[32] ? 34'sh0_8000_0000 : 34'sd0;
            end
            S_C_AFIN: r_t <= r_cz[31:0];
            S_C_KFIX: r_k <= k_fix;
            S_C_FSTART: begin
                // Surface point angle: floor(j * 2^32 / m).
                r_drem <= {20'd0, j_sel};
                r_dnum <= '0;
                r_dden <= {20'd0, r_m};
                r_dquo <= '0;
                r_dcnt <= 7'd32;
            end
            S_C_SFIN, S_Q_SFIN: begin
                r_cs <= q_cs;
                r_sn <= q_sn;
            end
            S_C_EYM:  r_ex <= dx36 - p_sh_cs[35:0];
            S_C_EXSQ: r_ey <= dy36 - p_sh_sn[35:0];
            S_C_EYSQ: r_s  <= {2'b00, r_prod};
            S_C_HSQ:  r_s  <= r_s + {2'b00, r_prod};
            S_Q_P2:   r_acc <= sgn_prod(r_prod, r_cs[32] ^ r_dx[32]);
            S_Q_P3:   r_rx  <= 36'((r_acc + sgn_prod(r_prod, r_sn[32] ^ r_dy[32])) >>> 30);
            S_Q_P4:   r_acc <= sgn_prod(r_prod, r_cs[32] ^ r_dy[32]);
            S_Q_RY:   r_ry  <= 36'((r_acc - sgn_prod(r_prod, r_sn[32] ^ r_dx[32])) >>> 30);
            default: begin
            end
        endcase

        // CORDIC iterations.
        if (r_state == S_C_AWAIT || r_state == S_C_SWAIT || r_state == S_Q_SWAIT) begin
            r_cstep <= r_cstep + 5'd1;
            if (c_pos) begin
                r_cx <= r_cx - cy_sh;
                r_cy <= r_cy + cx_sh;
                r_cz <= r_cz - c_atan;
            end else begin
                r_cx <= r_cx + cy_sh;
                r_cy <= r_cy - cx_sh;
                r_cz <= r_cz + c_atan;
            end
        end

        // Divider iterations.
        if (r_state == S_C_MWAIT || r_state == S_C_FWAIT) begin
            r_drem <= d_ge ? 60'(d_rem2 - {1'b0, r_dden}) : d_rem2[59:0];
            r_dnum <= {r_dnum[62:0], 1'b0};
            r_dquo <= {r_dquo[62:0], d_ge};
            r_dcnt <= r_dcnt - 7'd1;
        end
    end

endmodule

[src/prbc_checker.sv]
// Port level checks on the classifier, bound to its top level.
`timescale 1ns / 1ps

module prbc_checker
    import prbc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_in_opcode,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_out_outcome,
    input logic [3:0] o_out_hit_index
);

    // A pending result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_outcome) && $stable(o_out_hit_index))
        else $error("result changed while stalled");

    // Only the three verdicts appear.
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_outcome == OUT_DEEP || o_out_outcome == OUT_HIT
                         || o_out_outcome == OUT_OUTSIDE))
        else $error("bad outcome code");

    // The hit index is zero unless a body was hit.
    a_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_outcome != OUT_HIT |-> o_out_hit_index == 4'd0)
        else $error("hit index set without a hit");

    // A query transfer starts a walk, so the input side closes.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_opcode == OP_QUERY |=> !o_in_ready)
        else $error("input open during a query");

endmodule

bind point_in_rigid_body_classifier_core prbc_checker u_prbc_checker (.*);
